[hw/rtl/icymd_pkg.sv]
// Shared types, constants and the StreamTitle prefix table for the ICY
// metadata stream demultiplexer. No dependencies.
package icymd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned INTERVAL_W   = 27;
  localparam int unsigned META_CNT_W   = 12;
  localparam int unsigned PP_W         = 4;
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [META_CNT_W-1:0] MAX_META_BYTES   = 12'd4080;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = 27'd16000;
  localparam logic [PP_W-1:0]       PREFIX_LEN       = 4'd13;

  localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h27;

  // register index, from paddr[2]
  localparam logic [0:0] REG_ENABLE   = 1'b0;
  localparam logic [0:0] REG_INTERVAL = 1'b1;

  typedef enum logic {
    PH_AUDIO = 1'b0,
    PH_META  = 1'b1
  } phase_t;

  typedef struct packed {
    logic                  enable;
    logic [INTERVAL_W-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic              audio_valid;
    logic [BYTE_W-1:0] audio_byte;
    logic              title_char_valid;
    logic [BYTE_W-1:0] title_char;
    logic              title_discard;
    logic              block_end;
    logic              title_found;
    logic              format_error;
  } result_t;

  // StreamTitle=' one character per index
  function automatic logic [BYTE_W-1:0] prefix_char(input logic [PP_W-1:0] idx);
    logic [BYTE_W-1:0] ch;
    case (idx)
      4'd0:    ch = 8'h53; // S
      4'd1:    ch = 8'h74; // t
      4'd2:    ch = 8'h72; // r
      4'd3:    ch = 8'h65; // e
      4'd4:    ch = 8'h61; // a
      4'd5:    ch = 8'h6D; // m
      4'd6:    ch = 8'h54; // T
      4'd7:    ch = 8'h69; // i
      4'd8:    ch = 8'h74; // t
      4'd9:    ch = 8'h6C; // l
      4'd10:   ch = 8'h65; // e
      4'd11:   ch = 8'h3D; // =
      4'd12:   ch = 8'h27; // '
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[hw/rtl/icymd_stream_if.sv]
// Valid/ready channel interfaces for the stream byte input and the result
// output. Depends on icymd_pkg.
interface icymd_in_if;
  logic                          valid;
  logic                          ready;
  logic [icymd_pkg::BYTE_W-1:0]  stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface icymd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          audio_valid;
  logic [icymd_pkg::BYTE_W-1:0]  audio_byte;
  logic                          title_char_valid;
  logic [icymd_pkg::BYTE_W-1:0]  title_char;
  logic                          title_discard;
  logic                          block_end;
  logic                          title_found;
  logic                          format_error;

  modport source (output valid, output audio_valid, output audio_byte,
                  output title_char_valid, output title_char, output title_discard,
                  output block_end, output title_found, output format_error,
                  input ready);
  modport sink   (input valid, input audio_valid, input audio_byte,
                  input title_char_valid, input title_char, input title_discard,
                  input block_end, input title_found, input format_error,
                  output ready);
endinterface

[hw/rtl/icymd_cfg.sv]
// APB-style configuration registers: metadata enable and metadata interval.
// Depends on icymd_pkg.
module icymd_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [icymd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [icymd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [icymd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready,
  output icymd_pkg::cfg_t                     cfg_o
);

  logic                               enable_r;
  logic [icymd_pkg::INTERVAL_W-1:0]   interval_r;
  logic                               wr_en;
  logic [0:0]                         reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[2:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      interval_r <= icymd_pkg::INTERVAL_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        icymd_pkg::REG_ENABLE:   enable_r   <= cfg_pwdata[0];
        icymd_pkg::REG_INTERVAL: interval_r <= cfg_pwdata[icymd_pkg::INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      icymd_pkg::REG_ENABLE:
        cfg_prdata = {{(icymd_pkg::CFG_DATA_W-1){1'b0}}, enable_r};
      icymd_pkg::REG_INTERVAL:
        cfg_prdata = {{(icymd_pkg::CFG_DATA_W-icymd_pkg::INTERVAL_W){1'b0}}, interval_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  assign cfg_o.enable   = enable_r;
  assign cfg_o.interval = interval_r;

endmodule

[hw/rtl/icymd_core.sv]
// Per-byte demux and StreamTitle matcher: holds the phase, counters and
// matcher flags and computes one result per stepped byte. Depends on icymd_pkg.
module icymd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_i,
  input  logic [icymd_pkg::BYTE_W-1:0]  byte_i,
  input  icymd_pkg::cfg_t               cfg_i,
  output icymd_pkg::result_t            res_o
);

  icymd_pkg::phase_t                  phase_r, phase_nxt;
  logic [icymd_pkg::INTERVAL_W-1:0]   cnt_r, cnt_nxt;
  logic [icymd_pkg::META_CNT_W-1:0]   rem_r, rem_nxt;
  logic [icymd_pkg::PP_W-1:0]         pp_r, pp_nxt;
  logic                               act_r, act_nxt;
  logic                               nonempty_r, nonempty_nxt;
  logic                               qp_r, qp_nxt;
  logic                               rp_r, rp_nxt;
  logic                               tm_r, tm_nxt;
  logic                               zs_r, zs_nxt;

  logic                               interval_hit;
  logic                               last_meta;
  logic [icymd_pkg::META_CNT_W-1:0]   blk_len;

  assign interval_hit = (cnt_r >= cfg_i.interval);
  assign last_meta    = (rem_r <= icymd_pkg::META_CNT_W'(1));

  always_comb begin
    blk_len = {byte_i, 4'b0000};
    if (blk_len > icymd_pkg::MAX_META_BYTES) begin
      blk_len = icymd_pkg::MAX_META_BYTES;
    end
  end

  // phase
  always_comb begin
    phase_nxt = phase_r;
    if (step_i && cfg_i.enable) begin
      case (phase_r)
        icymd_pkg::PH_AUDIO: begin
          if (interval_hit && (byte_i != '0)) begin
            phase_nxt = icymd_pkg::PH_META;
          end
        end
        icymd_pkg::PH_META: begin
          if (last_meta) begin
            phase_nxt = icymd_pkg::PH_AUDIO;
          end
        end
        default: phase_nxt = icymd_pkg::PH_AUDIO;
      endcase
    end
  end

  // counters, matcher and result
  always_comb begin
    logic [icymd_pkg::PP_W-1:0] np;
    logic                       prefix_done;
    res_o        = '0;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    pp_nxt       = pp_r;
    act_nxt      = act_r;
    nonempty_nxt = nonempty_r;
    qp_nxt       = qp_r;
    rp_nxt       = rp_r;
    tm_nxt       = tm_r;
    zs_nxt       = zs_r;
    np           = '0;
    prefix_done  = 1'b0;

    if (!cfg_i.enable) begin
      res_o.audio_valid = 1'b1;
      res_o.audio_byte  = byte_i;
    end else if (phase_r == icymd_pkg::PH_AUDIO) begin
      if (!interval_hit) begin
        res_o.audio_valid = 1'b1;
        res_o.audio_byte  = byte_i;
        cnt_nxt           = cnt_r + 1'b1;
      end else begin
        cnt_nxt = '0;
        if (byte_i != '0) begin
          rem_nxt      = blk_len;
          pp_nxt       = '0;
          act_nxt      = 1'b0;
          nonempty_nxt = 1'b0;
          qp_nxt       = 1'b0;
          rp_nxt       = 1'b0;
          tm_nxt       = 1'b0;
          zs_nxt       = 1'b0;
        end
      end
    end else begin
      if (!zs_r && !tm_r) begin
        if (byte_i == '0) begin
          zs_nxt = 1'b1;
          if (nonempty_r || qp_r) begin
            res_o.title_discard = 1'b1;
          end
          act_nxt      = 1'b0;
          nonempty_nxt = 1'b0;
          qp_nxt       = 1'b0;
          rp_nxt       = 1'b0;
        end else begin
          if ((pp_r < icymd_pkg::PREFIX_LEN) && (byte_i == icymd_pkg::prefix_char(pp_r))) begin
            np = pp_r + 1'b1;
          end else begin
            np = (byte_i == icymd_pkg::CH_S) ? icymd_pkg::PP_W'(1) : '0;
          end
          if (np >= icymd_pkg::PREFIX_LEN) begin
            prefix_done = 1'b1;
            np          = '0;
          end
          pp_nxt = np;

          if (qp_r) begin
            qp_nxt = 1'b0;
            if (byte_i == icymd_pkg::CH_SEMI) begin
              tm_nxt  = 1'b1;
              act_nxt = 1'b0;
              rp_nxt  = 1'b0;
            end else begin
              res_o.title_discard = 1'b1;
              act_nxt             = 1'b0;
              nonempty_nxt        = 1'b0;
              if (rp_r) begin
                rp_nxt = 1'b0;
                if (byte_i != icymd_pkg::CH_QUOTE) begin
                  act_nxt                = 1'b1;
                  nonempty_nxt           = 1'b1;
                  res_o.title_char_valid = 1'b1;
                  res_o.title_char       = byte_i;
                end
              end
            end
          end else if (act_r) begin
            if (byte_i == icymd_pkg::CH_QUOTE) begin
              act_nxt = 1'b0;
              if (nonempty_r) begin
                qp_nxt      = 1'b1;
                rp_nxt      = prefix_done;
                prefix_done = 1'b0;
              end
              nonempty_nxt = 1'b0;
            end else begin
              nonempty_nxt           = 1'b1;
              res_o.title_char_valid = 1'b1;
              res_o.title_char       = byte_i;
            end
          end

          if (prefix_done && !act_nxt && !qp_nxt) begin
            act_nxt      = 1'b1;
            nonempty_nxt = 1'b0;
          end
        end
      end

      if (last_meta) begin
        rem_nxt         = '0;
        res_o.block_end = 1'b1;
        if (tm_nxt) begin
          res_o.title_found = 1'b1;
        end else begin
          res_o.format_error = 1'b1;
          if ((act_nxt && nonempty_nxt) || qp_nxt) begin
            res_o.title_discard = 1'b1;
          end
        end
        cnt_nxt      = '0;
        pp_nxt       = '0;
        act_nxt      = 1'b0;
        nonempty_nxt = 1'b0;
        qp_nxt       = 1'b0;
        rp_nxt       = 1'b0;
        tm_nxt       = 1'b0;
        zs_nxt       = 1'b0;
      end else begin
        rem_nxt = rem_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= icymd_pkg::PH_AUDIO;
      cnt_r      <= '0;
      rem_r      <= '0;
      pp_r       <= '0;
      act_r      <= 1'b0;
      nonempty_r <= 1'b0;
      qp_r       <= 1'b0;
      rp_r       <= 1'b0;
      tm_r       <= 1'b0;
      zs_r       <= 1'b0;
    end else if (step_i) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      rem_r      <= rem_nxt;
      pp_r       <= pp_nxt;
      act_r      <= act_nxt;
      nonempty_r <= nonempty_nxt;
      qp_r       <= qp_nxt;
      rp_r       <= rp_nxt;
      tm_r       <= tm_nxt;
      zs_r       <= zs_nxt;
    end
  end

endmodule

[hw/rtl/icy_metadata_stream_demux.sv]
// Top level of the ICY metadata stream demultiplexer: input register, core,
// result register and configuration registers. Depends on icymd_pkg,
// icymd_stream_if, icymd_cfg and icymd_core.

// Takes one stream byte per beat and returns exactly one result beat per
// byte, sustaining one byte per clock cycle while out_m.ready does not hold
// back the result; the byte goes through an input register, then the core's
// demux and StreamTitle matcher update combinationally, then a result
// register. Results come out in input order. Configuration registers
// (metadata_enable at 0x0, meta_interval at 0x4) are written over the APB
// port and should only change while no byte is in flight.
module icy_metadata_stream_demux (
  input  logic                              clk,
  input  logic                              rst_n,
  icymd_in_if.sink                          in_s,
  icymd_out_if.source                       out_m,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [icymd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [icymd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [icymd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  icymd_pkg::cfg_t               cfg;
  icymd_pkg::result_t            res;
  icymd_pkg::result_t            res_r;
  logic                          in_vld_r;
  logic [icymd_pkg::BYTE_W-1:0]  in_byte_r;
  logic                          out_vld_r;
  logic                          adv;
  logic                          step;

  icymd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  assign adv        = !out_vld_r || out_m.ready;
  assign step       = in_vld_r && adv;
  assign in_s.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_s.ready) begin
      in_vld_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.ready) begin
      in_byte_r <= in_s.stream_byte;
    end
  end

  icymd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (in_byte_r),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_m.valid            = out_vld_r;
  assign out_m.audio_valid      = res_r.audio_valid;
  assign out_m.audio_byte       = res_r.audio_byte;
  assign out_m.title_char_valid = res_r.title_char_valid;
  assign out_m.title_char       = res_r.title_char;
  assign out_m.title_discard    = res_r.title_discard;
  assign out_m.block_end        = res_r.block_end;
  assign out_m.title_found      = res_r.title_found;
  assign out_m.format_error     = res_r.format_error;

`ifndef SYNTHESIS
  a_status_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.title_found || res_r.format_error) |-> res_r.block_end)
    else $error("title_found or format_error without block_end");

  a_end_one_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.block_end |-> (res_r.title_found != res_r.format_error))
    else $error("block_end needs exactly one of title_found and format_error");

  a_audio_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.audio_valid |->
      !res_r.title_char_valid && !res_r.block_end && !res_r.title_discard)
    else $error("audio beat carries metadata flags");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("stepped byte did not reach the result register");
`endif

endmodule
